[hw/rtl/amu_pkg.sv]
// Shared types and constants for the Adam moment update block.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package amu_pkg;

  localparam int SLOT_COUNT_DEF = 4096;
  localparam int SLOT_W         = 12;
  localparam int DATA_W         = 32;
  localparam int ROOT_W         = 29;
  localparam int CFG_IDX_W      = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BETA_FIRST   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_SECOND  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON_TERM = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE    = 8'd3;

  localparam logic [15:0] BETA_FIRST_RST   = 16'd58982;
  localparam logic [15:0] BETA_SECOND_RST  = 16'd65470;
  localparam logic [31:0] EPSILON_TERM_RST = 32'd1;
  localparam logic [31:0] STEP_RATE_RST    = 32'd16777;

  localparam logic cmd_update = 1'b0;
  localparam logic cmd_clear  = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [SLOT_W-1:0]        slot_index;
    logic signed [DATA_W-1:0] gradient;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]        result_slot;
    logic signed [DATA_W-1:0] update_value;
  } out_t;

  // item bookkeeping that rides along the root and divide pipelines
  typedef struct packed {
    logic              res;
    logic [SLOT_W-1:0] slot;
    logic              mneg;
    logic              mzero;
  } side_t;

endpackage

[hw/rtl/amu_moment_store.sv]
// Moment memory with read-modify-write, forwarding and the clearing pass after reset.
// Produces the radicand, the scaled numerator and the item sideband. Uses amu_pkg.
`timescale 1ns / 1ps

module amu_moment_store #(
  parameter int SLOT_COUNT = amu_pkg::SLOT_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           take,
  input  amu_pkg::in_t   item,
  input  logic [15:0]    beta_first,
  input  logic [15:0]    beta_second,
  input  logic [31:0]    epsilon_term,
  input  logic [31:0]    step_rate,
  output logic           busy,
  output logic [32:0]    rad,
  output logic [63:0]    num,
  output amu_pkg::side_t side
);
  import amu_pkg::*;

  localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [63:0] mem [SLOT_COUNT];
  logic [63:0] rd_data;

  logic [ADDR_W-1:0] clr_addr;

  // stage 1
  logic              v1, cmd1, inr1;
  logic [SLOT_W-1:0] slot1;
  logic [ADDR_W-1:0] addr1;
  logic signed [31:0] g1;
  // stage 2
  logic              v2, cmd2, inr2;
  logic [SLOT_W-1:0] slot2;
  logic [ADDR_W-1:0] addr2;
  logic signed [49:0] pg2;
  logic [31:0]       gsq2;
  logic [63:0]       old2;
  // stage 3 (new moments) and stage 4 (forward copy)
  logic              res3, we3, we4;
  logic [SLOT_W-1:0] slot3;
  logic [ADDR_W-1:0] addr3, addr4;
  logic signed [31:0] m3, m4;
  logic [31:0]       vm3, vm4;

  logic [ADDR_W-1:0] in_addr;
  logic              in_range;
  logic [16:0]       omb1, omb2;
  logic [31:0]       gmag;
  logic [63:0]       gg;
  logic [39:0]       gs;
  logic signed [49:0] pg_next;
  logic [31:0]       gsq_next;
  logic signed [31:0] m_old;
  logic [31:0]       v_old;
  logic signed [49:0] macc;
  logic [49:0]       vacc;
  logic signed [31:0] m_next;
  logic [31:0]       v_next;
  logic              we2;
  logic [31:0]       mmag;

  assign in_addr  = ADDR_W'(32'(item.slot_index));
  assign in_range = 32'(item.slot_index) < 32'(SLOT_COUNT);
  assign omb1     = 17'h10000 - {1'b0, beta_first};
  assign omb2     = 17'h10000 - {1'b0, beta_second};

  // stage 1 arithmetic: gradient products while the memory reads
  always_comb begin
    gmag     = g1[31] ? (~g1 + 32'd1) : g1;
    gg       = 64'(gmag) * 64'(gmag);
    gs       = 40'((gg + 64'h80_0000) >> 24);
    gsq_next = (|gs[39:32]) ? 32'hFFFF_FFFF : gs[31:0];
    pg_next  = 50'($signed({1'b0, omb1}) * g1);
  end

  // stage 2: take the freshest moments, then blend them, or zero them for a clear
  always_comb begin
    priority if (we3 && addr3 == addr2) begin
      m_old = m3;
      v_old = vm3;
    end else if (we4 && addr4 == addr2) begin
      m_old = m4;
      v_old = vm4;
    end else begin
      m_old = old2[63:32];
      v_old = old2[31:0];
    end
    macc = 50'($signed({1'b0, beta_first}) * m_old) + pg2;
    vacc = 50'(beta_second) * 50'(v_old) + 50'(omb2) * 50'(gsq2);
    if (cmd2 == cmd_clear) begin
      m_next = '0;
      v_next = '0;
    end else begin
      m_next = 32'((macc + 50'sd32768) >>> 16);
      v_next = 32'((vacc + 50'd32768) >> 16);
    end
    we2  = v2 && inr2;
    mmag = m3[31] ? (~m3 + 32'd1) : m3;
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (we2 && advance) begin
      mem[addr2] <= {m_next, v_next};
    end
    if (advance) begin
      rd_data <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == ADDR_W'(SLOT_COUNT - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      res3 <= 1'b0;
      we3  <= 1'b0;
      we4  <= 1'b0;
      side <= '0;
    end else if (advance) begin
      v1    <= take;
      cmd1  <= item.cmd;
      inr1  <= in_range;
      slot1 <= item.slot_index;
      addr1 <= in_addr;
      g1    <= item.gradient;

      v2    <= v1;
      cmd2  <= cmd1;
      inr2  <= inr1;
      slot2 <= slot1;
      addr2 <= addr1;
      pg2   <= pg_next;
      gsq2  <= gsq_next;
      old2  <= rd_data;

      res3  <= we2 && (cmd2 == cmd_update);
      we3   <= we2;
      slot3 <= slot2;
      addr3 <= addr2;
      m3    <= m_next;
      vm3   <= v_next;

      we4   <= we3;
      addr4 <= addr3;
      m4    <= m3;
      vm4   <= vm3;

      rad        <= {1'b0, vm3} + {1'b0, epsilon_term};
      num        <= 64'(step_rate) * 64'(mmag);
      side.res   <= res3;
      side.slot  <= slot3;
      side.mneg  <= m3[31];
      side.mzero <= (m3 == '0);
    end
  end

endmodule

[hw/rtl/amu_sqrt_pipe.sv]
// Pipelined integer square root of (rad << 24), one root bit per stage.
// Carries the numerator and sideband alongside. Uses amu_pkg.
`timescale 1ns / 1ps

module amu_sqrt_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [32:0]                rad,
  input  logic [63:0]                num,
  input  amu_pkg::side_t             side,
  output logic [amu_pkg::ROOT_W-1:0] root,
  output logic [63:0]                num_out,
  output amu_pkg::side_t             side_out
);
  import amu_pkg::*;

  localparam int STEPS = ROOT_W;
  localparam int X_W   = 2 * ROOT_W;

  logic [29:0]       rem_q    [STEPS];
  logic [ROOT_W-1:0] root_q   [STEPS];
  logic [X_W-1:0]    x_q      [STEPS];
  logic [63:0]       num_q    [STEPS];
  side_t             side_q   [STEPS];
  logic [29:0]       rem_next [STEPS];
  logic [ROOT_W-1:0] root_next[STEPS];
  logic [X_W-1:0]    x_next   [STEPS];

  always_comb begin
    logic [29:0]       r_src;
    logic [ROOT_W-1:0] q_src;
    logic [X_W-1:0]    x_src;
    logic [31:0]       shifted;
    logic [31:0]       trial;
    for (int i = 0; i < STEPS; i++) begin
      if (i == 0) begin
        r_src = '0;
        q_src = '0;
        x_src = {1'b0, rad, 24'b0};
      end else begin
        r_src = rem_q[i-1];
        q_src = root_q[i-1];
        x_src = x_q[i-1];
      end
      shifted = {r_src, x_src[X_W-1 -: 2]};
      trial   = {1'b0, q_src, 2'b01};
      if (shifted >= trial) begin
        rem_next[i]  = 30'(shifted - trial);
        root_next[i] = {q_src[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[i]  = shifted[29:0];
        root_next[i] = {q_src[ROOT_W-2:0], 1'b0};
      end
      x_next[i] = {x_src[X_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STEPS; i++) begin
        side_q[i] <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i < STEPS; i++) begin
        rem_q[i]  <= rem_next[i];
        root_q[i] <= root_next[i];
        x_q[i]    <= x_next[i];
        if (i == 0) begin
          num_q[i]  <= num;
          side_q[i] <= side;
        end else begin
          num_q[i]  <= num_q[i-1];
          side_q[i] <= side_q[i-1];
        end
      end
    end
  end

  assign root     = root_q[STEPS-1];
  assign num_out  = num_q[STEPS-1];
  assign side_out = side_q[STEPS-1];

endmodule

[hw/rtl/amu_div_pipe.sv]
// Pipelined rounded division (num + root/2) / root, one quotient bit per stage,
// with an overflow flag for quotients of 2^32 or more. Uses amu_pkg.
`timescale 1ns / 1ps

module amu_div_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [amu_pkg::ROOT_W-1:0] root,
  input  logic [63:0]                num,
  input  amu_pkg::side_t             side,
  output logic [31:0]                quot,
  output logic                       ovf,
  output amu_pkg::side_t             side_out
);
  import amu_pkg::*;

  localparam int STEPS = 32;

  // entry stage
  logic [64:0]       n_sum;
  logic [ROOT_W-1:0] r0;
  logic [31:0]       low0;
  logic [ROOT_W-1:0] d0;
  logic              ovf0;
  side_t             side0;

  logic [ROOT_W-1:0] rem_q  [STEPS];
  logic [31:0]       low_q  [STEPS];
  logic [31:0]       quot_q [STEPS];
  logic [ROOT_W-1:0] d_q    [STEPS];
  logic              ovf_q  [STEPS];
  side_t             side_q [STEPS];
  logic [ROOT_W-1:0] rem_next [STEPS];
  logic [31:0]       quot_next[STEPS];

  assign n_sum = {1'b0, num} + 65'(root >> 1);

  always_comb begin
    logic [ROOT_W-1:0] r_src;
    logic [31:0]       l_src;
    logic [31:0]       q_src;
    logic [ROOT_W-1:0] d_src;
    logic [ROOT_W:0]   t;
    for (int i = 0; i < STEPS; i++) begin
      if (i == 0) begin
        r_src = r0;
        l_src = low0;
        q_src = '0;
        d_src = d0;
      end else begin
        r_src = rem_q[i-1];
        l_src = low_q[i-1];
        q_src = quot_q[i-1];
        d_src = d_q[i-1];
      end
      t = {r_src, l_src[31]};
      if (t >= {1'b0, d_src}) begin
        rem_next[i]  = ROOT_W'(t - {1'b0, d_src});
        quot_next[i] = {q_src[30:0], 1'b1};
      end else begin
        rem_next[i]  = t[ROOT_W-1:0];
        quot_next[i] = {q_src[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side0 <= '0;
      for (int i = 0; i < STEPS; i++) begin
        side_q[i] <= '0;
      end
    end else if (advance) begin
      r0    <= n_sum[32 +: ROOT_W];
      low0  <= n_sum[31:0];
      d0    <= root;
      ovf0  <= n_sum[64:32] >= 33'(root);
      side0 <= side;
      for (int i = 0; i < STEPS; i++) begin
        rem_q[i]  <= rem_next[i];
        quot_q[i] <= quot_next[i];
        if (i == 0) begin
          low_q[i]  <= {low0[30:0], 1'b0};
          d_q[i]    <= d0;
          ovf_q[i]  <= ovf0;
          side_q[i] <= side0;
        end else begin
          low_q[i]  <= {low_q[i-1][30:0], 1'b0};
          d_q[i]    <= d_q[i-1];
          ovf_q[i]  <= ovf_q[i-1];
          side_q[i] <= side_q[i-1];
        end
      end
    end
  end

  assign quot     = quot_q[STEPS-1];
  assign ovf      = ovf_q[STEPS-1];
  assign side_out = side_q[STEPS-1];

endmodule

[hw/rtl/adam_moment_update.sv]
// Adam moment update: moment memory, root and divide pipelines, result register.
// Instantiates amu_moment_store, amu_sqrt_pipe and amu_div_pipe. Uses amu_pkg.
// After reset the block zeroes its moment memory, one slot a cycle, all SLOT_COUNT
// slots (4096 by default) with in_ready low. From then on it takes one item every
// cycle unless the pipeline stalls. Each item passes through the memory
// read-modify-write, the 29-stage square root, the 33-stage divider and the
// result register.
// Clear commands and slots out of range give no result. A waiting result stalls the
// pipeline only when another result is right behind it.
`timescale 1ns / 1ps

module adam_moment_update #(
  parameter int SLOT_COUNT = amu_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  amu_pkg::in_t                  in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output amu_pkg::out_t                 out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [amu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import amu_pkg::*;

  logic [15:0] beta_first, beta_second;
  logic [31:0] epsilon_term, step_rate;

  logic              busy, advance, take;
  logic [32:0]       rad;
  logic [63:0]       num, num_sq;
  side_t             side_st, side_sq, side_dv;
  logic [ROOT_W-1:0] root;
  logic [31:0]       quot;
  logic              ovf;
  logic [31:0]       update_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_first   <= BETA_FIRST_RST;
      beta_second  <= BETA_SECOND_RST;
      epsilon_term <= EPSILON_TERM_RST;
      step_rate    <= STEP_RATE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BETA_FIRST:   beta_first   <= cfg_data[15:0];
        REG_BETA_SECOND:  beta_second  <= cfg_data[15:0];
        REG_EPSILON_TERM: epsilon_term <= cfg_data;
        REG_STEP_RATE:    step_rate    <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold everything only when a result waits and another one is arriving
  assign advance  = !(out_valid && !out_ready && side_dv.res);
  assign in_ready = advance && !busy;
  assign take     = in_valid && in_ready;

  amu_moment_store #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .take         (take),
    .item         (in_item),
    .beta_first   (beta_first),
    .beta_second  (beta_second),
    .epsilon_term (epsilon_term),
    .step_rate    (step_rate),
    .busy         (busy),
    .rad          (rad),
    .num          (num),
    .side         (side_st)
  );

  amu_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .rad      (rad),
    .num      (num),
    .side     (side_st),
    .root     (root),
    .num_out  (num_sq),
    .side_out (side_sq)
  );

  amu_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .root     (root),
    .num      (num_sq),
    .side     (side_sq),
    .quot     (quot),
    .ovf      (ovf),
    .side_out (side_dv)
  );

  always_comb begin
    priority if (side_dv.mzero) begin
      update_next = '0;
    end else if (side_dv.mneg) begin
      update_next = (ovf || quot[31]) ? 32'h8000_0000 : (~quot + 32'd1);
    end else begin
      update_next = (ovf || quot >= 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && side_dv.res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && side_dv.res) begin
      out_item.result_slot  <= side_dv.slot;
      out_item.update_value <= update_next;
    end
  end

endmodule

[verif/adam_moment_update_checker.sv]
// Checker for the Adam moment update block: watches the input, output and config
// transfers, predicts each step from its own moment copy and compares. Uses amu_pkg.
`timescale 1ns / 1ps

module adam_moment_update_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  amu_pkg::in_t  in_item,
  input  logic          out_valid,
  input  logic          out_ready,
  input  amu_pkg::out_t out_item,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output int            fail_count,
  output int            steps_pending
);
  import amu_pkg::*;

  logic [15:0] beta1, beta2;
  logic [31:0] eps, rate;
  logic signed [31:0] mom1 [SLOT_COUNT_DEF];
  logic [31:0] mom2 [SLOT_COUNT_DEF];
  out_t step_queue [$];

  assign steps_pending = step_queue.size();

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // advance the slot's moments and return the step
  function automatic logic signed [31:0] moment_step(input logic [11:0] slot,
                                                     input logic signed [31:0] g);
    logic signed [63:0] macc, gl, u;
    logic signed [31:0] m;
    logic [63:0] gmag, gsq, vacc, root, num, mag;
    logic [31:0] v;
    gl = g;
    macc = $signed({48'd0, beta1}) * $signed(64'(mom1[slot]))
         + $signed(64'(17'h10000 - beta1)) * gl;
    m = 32'((macc + 64'sd32768) >>> 16);
    gmag = (g < 0) ? 64'(-gl) : 64'(gl);
    gsq = (gmag * gmag + (64'd1 << 23)) >> 24;
    if (gsq > 64'hFFFF_FFFF) gsq = 64'hFFFF_FFFF;
    vacc = 64'(beta2) * 64'(mom2[slot]) + 64'(17'h10000 - beta2) * gsq;
    v = 32'((vacc + 64'd32768) >> 16);
    mom1[slot] = m;
    mom2[slot] = v;
    root = int_sqrt((64'(v) + 64'(eps)) << 24);
    mag = (m < 0) ? 64'(-64'(m)) : 64'(m);
    num = 64'(rate) * mag;
    if (root == 0) begin
      if (m == 0) u = 0;
      else u = (m < 0) ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
    end else begin
      mag = (num + (root >> 1)) / root;
      if (m < 0) u = (mag >= 64'h8000_0000) ? -64'sh8000_0000 : -$signed(mag);
      else u = (mag >= 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : $signed(mag);
    end
    return 32'(u);
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      beta1 <= BETA_FIRST_RST;
      beta2 <= BETA_SECOND_RST;
      eps <= EPSILON_TERM_RST;
      rate <= STEP_RATE_RST;
      for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
        mom1[i] = 0;
        mom2[i] = 0;
      end
      step_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BETA_FIRST:   beta1 <= cfg_data[15:0];
          REG_BETA_SECOND:  beta2 <= cfg_data[15:0];
          REG_EPSILON_TERM: eps <= cfg_data;
          REG_STEP_RATE:    rate <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready && 32'(in_item.slot_index) < SLOT_COUNT_DEF) begin
        if (in_item.cmd == cmd_clear) begin
          mom1[in_item.slot_index] = 0;
          mom2[in_item.slot_index] = 0;
        end else begin
          want.result_slot = in_item.slot_index;
          want.update_value = moment_step(in_item.slot_index, in_item.gradient);
          step_queue.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        if (step_queue.size() == 0) begin
          $error("unexpected result slot %0d", out_item.result_slot);
          fail_count <= fail_count + 1;
        end else begin
          want = step_queue.pop_front();
          if (want.result_slot !== out_item.result_slot) begin
            $error("result_slot expected %0d actual %0d", want.result_slot,
                   out_item.result_slot);
            fail_count <= fail_count + 1;
          end else if (want.update_value !== out_item.update_value) begin
            $error("update_value expected %0d actual %0d", want.update_value,
                   out_item.update_value);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[verif/adam_moment_update_test.sv]
// Top of the Adam moment update testbench: clock, reset, stimulus and verdict.
// Depends on amu_pkg, adam_moment_update and adam_moment_update_checker.
`timescale 1ns / 1ps

module adam_moment_update_test;
  import amu_pkg::*;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_t in_item;
  out_t out_item;
  logic [7:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, steps_pending;
  bit hold_long, sink_on;

  adam_moment_update dut (.*);
  adam_moment_update_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls per transfer, one long hold-off
  initial begin
    int gap;
    out_ready = 0;
    @(posedge clk iff sink_on);
    forever begin
      if (hold_long) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_long = 0;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk iff out_valid);
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic c, input logic [11:0] s, input logic [31:0] g,
                           input bit burst);
    int gap;
    gap = burst ? 0 : (($urandom_range(3) == 0) ? 0 : $urandom_range(18));
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_item <= '{cmd: c, slot_index: s, gradient: g};
    @(posedge clk iff in_ready);
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (steps_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_grad;
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(2) << 24;
      3: return -($urandom_range(1 << 20));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [11:0] hot;
    rst = 1;
    in_valid = 0; in_item = '0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    sink_on = 1;
    // directed: extremes, clear, default settings
    send_item(cmd_update, 12'd0, 32'h7FFF_FFFF, 0);
    send_item(cmd_update, 12'd0, 32'h7FFF_FFFF, 0);
    send_item(cmd_update, 12'hFFF, 32'h8000_0000, 0);
    send_item(cmd_update, 12'd5, 32'd0, 0);
    send_item(cmd_update, 12'd6, 32'h0100_0000, 0);
    send_item(cmd_clear, 12'd0, 32'hFFFF_FFFF, 0);
    send_item(cmd_update, 12'd0, 32'd1, 0);
    send_item(cmd_update, 12'd7, 32'hFFFF_FFFF, 0);
    drain();
    // zero root: no epsilon, zero and nonzero moments
    write_reg(REG_EPSILON_TERM, 0);
    write_reg(REG_STEP_RATE, 32'hFFFF_FFFF);
    write_reg(REG_BETA_FIRST, 0);
    write_reg(REG_BETA_SECOND, 16'hFFFF);
    write_reg(8'd9, 32'h1234);
    send_item(cmd_update, 12'd20, 32'd0, 0);
    send_item(cmd_update, 12'd21, 32'd5, 0);
    send_item(cmd_update, 12'd22, -32'sd5, 0);
    send_item(cmd_update, 12'd23, 32'h7FFF_FFFF, 0);
    drain();
    write_reg(REG_BETA_FIRST, 16'hFFFF);
    write_reg(REG_BETA_SECOND, 0);
    write_reg(REG_EPSILON_TERM, 32'hFFFF_FFFF);
    write_reg(REG_STEP_RATE, 0);
    send_item(cmd_update, 12'd30, 32'h8000_0000, 0);
    send_item(cmd_update, 12'd31, 32'h7FFF_FFFF, 0);
    drain();
    // random phases, few slots so moments build up
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_BETA_FIRST, (ph % 2) ? $urandom : 16'd58982);
      write_reg(REG_BETA_SECOND, (ph % 3 == 0) ? 16'd65470 : $urandom);
      write_reg(REG_EPSILON_TERM, (ph == 3) ? $urandom : $urandom_range(1 << 12));
      write_reg(REG_STEP_RATE, (ph == 4) ? $urandom : $urandom_range(1 << 20));
      if (ph == 2) hold_long = 1;
      for (int k = 0; k < 220; k++) begin
        hot = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15));
        send_item(($urandom_range(9) == 0) ? cmd_clear : cmd_update, hot, pick_grad(),
                  ph == 2);
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
